@@ hdl/midpoint_circle_outline_core_macros.svh @@
// assertion macros shared by the circle rasterizer rtl
`ifndef MIDPOINT_CIRCLE_OUTLINE_CORE_MACROS_SVH
`define MIDPOINT_CIRCLE_OUTLINE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MPC_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define MPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define MPC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define MPC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ hdl/mpc_pkg.sv @@
package mpc_pkg;

	localparam int DEF_COORD_WIDTH = 16;

	// request kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [14:0] circle_radius;
		logic [15:0] ink;
	} req_item_t;

	typedef struct packed {
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [15:0] pixel_colour;
		logic        last_of_step;
		logic        circle_done;
	} pixel_item_t;

	// octant pixels in output order: offsets added to (cx, cy)
	typedef enum logic [2:0] {
		OCT_XP_YP,
		OCT_YP_XP,
		OCT_YN_XP,
		OCT_XN_YP,
		OCT_XN_YN,
		OCT_YN_XN,
		OCT_YP_XN,
		OCT_XP_YN
	} octant_t;

	localparam octant_t OCT_FIRST = OCT_XP_YP;
	localparam octant_t OCT_LAST  = OCT_XP_YN;

endpackage

@@ hdl/mpc_engine.sv @@
`include "midpoint_circle_outline_core_macros.svh"

module mpc_engine #(
	parameter int COORD_WIDTH = mpc_pkg::DEF_COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mpc_pkg::req_item_t     req,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   snap_free,
	output logic                   snap_load,
	output logic [COORD_WIDTH-1:0] snap_x,
	output logic [COORD_WIDTH-1:0] snap_y,
	output logic [COORD_WIDTH-1:0] snap_cx,
	output logic [COORD_WIDTH-1:0] snap_cy,
	output logic [15:0]            snap_colour,
	output logic                   snap_done
);

	mpc_pkg::req_item_t item_s1;
	logic               valid_s1;

	logic signed [16:0]    x_q;
	logic signed [16:0]    y_q;
	logic [17:0]           dx_q;
	logic [17:0]           dy_q;
	logic signed [19:0]    err_q;
	logic [COORD_WIDTH-1:0] cx_q;
	logic [COORD_WIDTH-1:0] cy_q;
	logic [14:0]           r_q;
	logic [15:0]           colour_q;
	logic                  active_q;

	logic                  is_start;
	logic                  go;
	logic                  err_le0;
	logic                  err1_gt0;
	logic signed [19:0]    err1;
	logic signed [19:0]    err2;
	logic signed [19:0]    two_r;
	logic [17:0]           dy1;
	logic [17:0]           dx1;
	logic signed [16:0]    x1;
	logic signed [16:0]    y1;
	logic                  done_next;

	assign is_start  = (item_s1.kind == mpc_pkg::KIND_START);
	// starts and idle steps never wait for the pixel side
	assign go        = valid_s1 && (is_start || !active_q || snap_free);
	assign req_stall = valid_s1 && !go;
	assign snap_load = go && !is_start && active_q;

	always_comb begin
		err_le0  = (err_q <= 20'sd0);
		err1     = err_le0 ? err_q + signed'({2'b00, dy_q}) : err_q;
		dy1      = err_le0 ? dy_q + 18'd2 : dy_q;
		y1       = err_le0 ? y_q + 17'sd1 : y_q;
		err1_gt0 = (err1 > 20'sd0);
		dx1      = err1_gt0 ? dx_q + 18'd2 : dx_q;
		two_r    = signed'({4'b0000, r_q, 1'b0});
		err2     = err1_gt0 ? err1 + signed'({2'b00, dx1}) - two_r : err1;
		x1       = err1_gt0 ? x_q - 17'sd1 : x_q;
		done_next = (x1 < y1);
	end

	assign snap_x      = x_q[COORD_WIDTH-1:0];
	assign snap_y      = y_q[COORD_WIDTH-1:0];
	assign snap_cx     = cx_q;
	assign snap_cy     = cy_q;
	assign snap_colour = colour_q;
	assign snap_done   = done_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			err_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			r_q      <= '0;
			colour_q <= '0;
			active_q <= 1'b0;
		end else if (go && is_start) begin
			cx_q     <= item_s1.center_x[COORD_WIDTH-1:0];
			cy_q     <= item_s1.center_y[COORD_WIDTH-1:0];
			r_q      <= item_s1.circle_radius;
			colour_q <= item_s1.ink;
			x_q      <= signed'({2'b00, item_s1.circle_radius}) - 17'sd1;
			y_q      <= '0;
			dx_q     <= 18'd1;
			dy_q     <= 18'd1;
			err_q    <= 20'sd1 - signed'({4'b0000, item_s1.circle_radius, 1'b0});
			active_q <= (item_s1.circle_radius != '0);
		end else if (snap_load) begin
			x_q      <= x1;
			y_q      <= y1;
			dx_q     <= dx1;
			dy_q     <= dy1;
			err_q    <= err2;
			active_q <= !done_next;
		end
	end

	`MPC_ASSERT_IMP(a_stall_needs_item, clk, arst_n, req_stall, valid_s1)
	`MPC_ASSERT_NEXT(a_done_ends_circle, clk, arst_n, snap_load && snap_done, !active_q)
	`MPC_ASSERT_IMP(a_active_in_octant, clk, arst_n, active_q, x_q >= y_q)

endmodule

@@ hdl/mpc_emitter.sv @@
`include "midpoint_circle_outline_core_macros.svh"

module mpc_emitter #(
	parameter int COORD_WIDTH = mpc_pkg::DEF_COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   snap_load,
	input  logic [COORD_WIDTH-1:0] snap_x,
	input  logic [COORD_WIDTH-1:0] snap_y,
	input  logic [COORD_WIDTH-1:0] snap_cx,
	input  logic [COORD_WIDTH-1:0] snap_cy,
	input  logic [15:0]            snap_colour,
	input  logic                   snap_done,
	output logic                   snap_free,
	output mpc_pkg::pixel_item_t   pixel,
	output logic                   pixel_valid,
	input  logic                   pixel_stall
);

	logic                   busy_q;
	logic [2:0]             idx_q;
	logic [COORD_WIDTH-1:0] sx_q;
	logic [COORD_WIDTH-1:0] sy_q;
	logic [COORD_WIDTH-1:0] scx_q;
	logic [COORD_WIDTH-1:0] scy_q;
	logic [15:0]            scol_q;
	logic                   sdone_q;

	mpc_pkg::pixel_item_t   out_q;
	logic                   out_valid_q;

	logic                   out_free;
	logic                   emit;
	logic                   last_idx;
	logic [COORD_WIDTH-1:0] off_x;
	logic [COORD_WIDTH-1:0] off_y;
	logic [COORD_WIDTH-1:0] px;
	logic [COORD_WIDTH-1:0] py;
	mpc_pkg::pixel_item_t   pix_d;

	assign out_free  = !out_valid_q || !pixel_stall;
	assign emit      = busy_q && out_free;
	assign last_idx  = (mpc_pkg::octant_t'(idx_q) == mpc_pkg::OCT_LAST);
	// the next step may load while the eighth pixel goes out
	assign snap_free = !busy_q || (emit && last_idx);

	always_comb begin
		case (mpc_pkg::octant_t'(idx_q))
			mpc_pkg::OCT_XP_YP: begin off_x = sx_q;  off_y = sy_q;  end
			mpc_pkg::OCT_YP_XP: begin off_x = sy_q;  off_y = sx_q;  end
			mpc_pkg::OCT_YN_XP: begin off_x = -sy_q; off_y = sx_q;  end
			mpc_pkg::OCT_XN_YP: begin off_x = -sx_q; off_y = sy_q;  end
			mpc_pkg::OCT_XN_YN: begin off_x = -sx_q; off_y = -sy_q; end
			mpc_pkg::OCT_YN_XN: begin off_x = -sy_q; off_y = -sx_q; end
			mpc_pkg::OCT_YP_XN: begin off_x = sy_q;  off_y = -sx_q; end
			mpc_pkg::OCT_XP_YN: begin off_x = sx_q;  off_y = -sy_q; end
			default:            begin off_x = sx_q;  off_y = sy_q;  end
		endcase
		// coordinates wrap at the coordinate width
		px = scx_q + off_x;
		py = scy_q + off_y;
		pix_d = '0;
		pix_d.pixel_x[COORD_WIDTH-1:0] = px;
		pix_d.pixel_y[COORD_WIDTH-1:0] = py;
		pix_d.pixel_colour = scol_q;
		pix_d.last_of_step = last_idx;
		pix_d.circle_done  = last_idx && sdone_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'(mpc_pkg::OCT_FIRST);
		end else begin
			if (snap_load) begin
				busy_q <= 1'b1;
			end else if (emit && last_idx) begin
				busy_q <= 1'b0;
			end
			if (snap_load) begin
				idx_q <= 3'(mpc_pkg::OCT_FIRST);
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_load) begin
			sx_q    <= snap_x;
			sy_q    <= snap_y;
			scx_q   <= snap_cx;
			scy_q   <= snap_cy;
			scol_q  <= snap_colour;
			sdone_q <= snap_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= pix_d;
		end
	end

	assign pixel       = out_q;
	assign pixel_valid = out_valid_q;

	`MPC_ASSERT_IMP(a_load_when_free, clk, arst_n, snap_load, snap_free)
	`MPC_ASSERT_NEXT(a_busy_after_last, clk, arst_n, emit && last_idx, busy_q == $past(snap_load))
	`MPC_ASSERT_IMP(a_done_on_last, clk, arst_n, out_valid_q && out_q.circle_done, out_q.last_of_step)

endmodule

@@ hdl/midpoint_circle_outline_core.sv @@
// step request: the accepted request is registered, its offsets are copied into the
// emitter snapshot, and its eight pixels leave the output register one per cycle
// while pixel_stall is low; start requests and steps with no active circle emit
// nothing and never wait; the next step can load while the last pixel is emitted
// async active-low reset: no circle active, all valids low, circle state zero

module midpoint_circle_outline_core #(
	parameter int COORD_WIDTH = mpc_pkg::DEF_COORD_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mpc_pkg::req_item_t   req,
	input  logic                 req_valid,
	output logic                 req_stall,
	output mpc_pkg::pixel_item_t pixel,
	output logic                 pixel_valid,
	input  logic                 pixel_stall
);

	logic                   snap_free;
	logic                   snap_load;
	logic [COORD_WIDTH-1:0] snap_x;
	logic [COORD_WIDTH-1:0] snap_y;
	logic [COORD_WIDTH-1:0] snap_cx;
	logic [COORD_WIDTH-1:0] snap_cy;
	logic [15:0]            snap_colour;
	logic                   snap_done;

	mpc_engine #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.snap_free   (snap_free),
		.snap_load   (snap_load),
		.snap_x      (snap_x),
		.snap_y      (snap_y),
		.snap_cx     (snap_cx),
		.snap_cy     (snap_cy),
		.snap_colour (snap_colour),
		.snap_done   (snap_done)
	);

	mpc_emitter #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.snap_load   (snap_load),
		.snap_x      (snap_x),
		.snap_y      (snap_y),
		.snap_cx     (snap_cx),
		.snap_cy     (snap_cy),
		.snap_colour (snap_colour),
		.snap_done   (snap_done),
		.snap_free   (snap_free),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall)
	);

endmodule

@@ bench/tb_midpoint_circle_outline_core.sv @@
module tb_midpoint_circle_outline_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 300;
	localparam int CALM_ITEMS = 45;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int FLUSH_CYCLES = 20;

	typedef struct {
		mpc_pkg::req_item_t   rq;
		int                   n_pix;	// -1: left to the predictor
		mpc_pkg::pixel_item_t tail;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	mpc_pkg::req_item_t   req = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	mpc_pkg::pixel_item_t pixel;
	logic                 pixel_valid;
	logic                 pixel_stall = 1'b0;

	// circle state mirrored by the predictor
	logic signed [16:0] ofs_x = '0;
	logic signed [16:0] ofs_y = '0;
	logic signed [17:0] inc_x = '0;
	logic signed [17:0] inc_y = '0;
	logic signed [19:0] mid_err = '0;
	logic [15:0]        ctr_x = '0;
	logic [15:0]        ctr_y = '0;
	logic [14:0]        rad = '0;
	logic [15:0]        colour = '0;
	logic               drawing = 1'b0;

	mpc_pkg::pixel_item_t pending_pixels[$];

	int  mismatches = 0;
	int  pixels_checked = 0;
	int  starts = 0;
	int  draw_steps = 0;
	int  circles_done = 0;
	int  item_count = 0;
	int  idle_cycles = 0;
	int  hold_cnt = 0;
	bit  calm = 1'b0;

	midpoint_circle_outline_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// start request loads the circle; step request: eight mirrored pixels of the current offsets, then the midpoint update
	function automatic int rasterize_step(input mpc_pkg::req_item_t rq);
		logic [15:0]          ax;
		logic [15:0]          ay;
		logic [15:0]          px;
		logic [15:0]          py;
		logic                 finished;
		mpc_pkg::pixel_item_t p;
		mpc_pkg::octant_t     oct;
		if (rq.kind == mpc_pkg::KIND_START) begin
			ctr_x = rq.center_x;
			ctr_y = rq.center_y;
			rad = rq.circle_radius;
			colour = rq.ink;
			ofs_x = 17'(int'(rad) - 1);
			ofs_y = '0;
			inc_x = 18'sd1;
			inc_y = 18'sd1;
			mid_err = 20'(1 - 2 * int'(rad));
			drawing = (ofs_x >= ofs_y);
			return 0;
		end
		if (!drawing)
			return 0;
		ax = ofs_x[15:0];
		ay = ofs_y[15:0];
		if (mid_err <= 20'sd0) begin
			ofs_y = ofs_y + 17'sd1;
			mid_err = mid_err + inc_y;
			inc_y = inc_y + 18'sd2;
		end
		if (mid_err > 20'sd0) begin
			ofs_x = ofs_x - 17'sd1;
			inc_x = inc_x + 18'sd2;
			mid_err = mid_err + inc_x - 20'(2 * int'(rad));
		end
		finished = !(ofs_x >= ofs_y);
		if (finished)
			drawing = 1'b0;
		for (int k = 0; k < 8; k++) begin
			oct = mpc_pkg::octant_t'(k);
			case (oct)
				mpc_pkg::OCT_XP_YP: begin px = ctr_x + ax; py = ctr_y + ay; end
				mpc_pkg::OCT_YP_XP: begin px = ctr_x + ay; py = ctr_y + ax; end
				mpc_pkg::OCT_YN_XP: begin px = ctr_x - ay; py = ctr_y + ax; end
				mpc_pkg::OCT_XN_YP: begin px = ctr_x - ax; py = ctr_y + ay; end
				mpc_pkg::OCT_XN_YN: begin px = ctr_x - ax; py = ctr_y - ay; end
				mpc_pkg::OCT_YN_XN: begin px = ctr_x - ay; py = ctr_y - ax; end
				mpc_pkg::OCT_YP_XN: begin px = ctr_x + ay; py = ctr_y - ax; end
				default: begin px = ctr_x + ax; py = ctr_y - ay; end
			endcase
			p.pixel_x = px;
			p.pixel_y = py;
			p.pixel_colour = colour;
			p.last_of_step = (oct == mpc_pkg::OCT_LAST);
			p.circle_done = (oct == mpc_pkg::OCT_LAST) && finished;
			pending_pixels.push_back(p);
		end
		return 8;
	endfunction

	function automatic void check_pixel(input mpc_pkg::pixel_item_t want,
			input mpc_pkg::pixel_item_t got);
		if (got.pixel_x !== want.pixel_x) begin
			$error("pixel_x: expected %h, got %h", want.pixel_x, got.pixel_x);
			mismatches++;
		end
		if (got.pixel_y !== want.pixel_y) begin
			$error("pixel_y: expected %h, got %h", want.pixel_y, got.pixel_y);
			mismatches++;
		end
		if (got.pixel_colour !== want.pixel_colour) begin
			$error("pixel_colour: expected %h, got %h", want.pixel_colour, got.pixel_colour);
			mismatches++;
		end
		if (got.last_of_step !== want.last_of_step) begin
			$error("last_of_step: expected %b, got %b", want.last_of_step, got.last_of_step);
			mismatches++;
		end
		if (got.circle_done !== want.circle_done) begin
			$error("circle_done: expected %b, got %b", want.circle_done, got.circle_done);
			mismatches++;
		end
	endfunction

	function automatic row_t mk(input logic k, input logic [15:0] cx, input logic [15:0] cy,
			input logic [14:0] r, input logic [15:0] ink, input int n,
			input mpc_pkg::pixel_item_t tail);
		row_t row;
		row.rq.kind = k;
		row.rq.center_x = cx;
		row.rq.center_y = cy;
		row.rq.circle_radius = r;
		row.rq.ink = ink;
		row.n_pix = n;
		row.tail = tail;
		return row;
	endfunction

	function automatic mpc_pkg::req_item_t random_item(input logic k);
		mpc_pkg::req_item_t rq;
		rq.kind = k;
		rq.center_x = 16'($urandom);
		rq.center_y = 16'($urandom);
		rq.circle_radius = 15'($urandom);
		rq.ink = 16'($urandom);
		return rq;
	endfunction

	// centers near the edges make the outline wrap around
	function automatic logic [15:0] pick_center();
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom_range(0, 40));
			2: return 16'(65535 - $urandom_range(0, 40));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic offer(input mpc_pkg::req_item_t rq, output int n);
		int gap;
		gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= rq;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		n = rasterize_step(rq);
		if (rq.kind == mpc_pkg::KIND_START) begin
			starts++;
			item_count++;
		end else if (n > 0) begin
			draw_steps++;
			item_count++;
			if (pending_pixels[$].circle_done)
				circles_done++;
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic trace_circle();
		mpc_pkg::req_item_t rq;
		int                 r_pick;
		int                 budget;
		int                 n;
		r_pick = $urandom_range(0, 99);
		rq = random_item(mpc_pkg::KIND_START);
		rq.center_x = pick_center();
		rq.center_y = pick_center();
		if (r_pick < 5)
			rq.circle_radius = '0;
		else if (r_pick < 75)
			rq.circle_radius = 15'($urandom_range(1, 24));
		else if (r_pick < 90)
			rq.circle_radius = 15'($urandom_range(25, 60));
		else
			rq.circle_radius = 15'($urandom_range(61, 32767));
		// large circles get 1 to 8 steps; one in ten of the others is dropped after 1 to 6 steps
		if (r_pick >= 90)
			budget = $urandom_range(1, 8);
		else if ($urandom_range(0, 9) == 0)
			budget = $urandom_range(1, 6);
		else
			budget = 1 << 20;
		offer(rq, n);
		while (drawing && budget > 0) begin
			offer(random_item(mpc_pkg::KIND_STEP), n);
			budget--;
		end
		if (!drawing)
			repeat ($urandom_range(0, 2)) offer(random_item(mpc_pkg::KIND_STEP), n);
	endtask

	// receiver stall in random bursts, separated by random run stretches
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			pixel_stall <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			pixel_stall <= 1'b1;
			hold_cnt <= $urandom_range(0, 9);
		end else begin
			pixel_stall <= 1'b0;
			hold_cnt <= $urandom_range(0, 15);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				pixels_checked++;
				if (pending_pixels.size() == 0) begin
					$error("pixel: none expected, got x=%h y=%h", pixel.pixel_x, pixel.pixel_y);
					mismatches++;
				end else begin
					check_pixel(pending_pixels.pop_front(), pixel);
				end
			end
			if ((pixel_valid && !pixel_stall) || (req_valid && !req_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no request or pixel moved for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_midpoint_circle_outline_core failed");
				$finish;
			end
		end
	end

	initial begin
		row_t script[$];
		int   n;
		int   target;
		int   choice;
		script = '{
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'h0000, 16'h0000, 0, '0),
			mk(mpc_pkg::KIND_START, 16'h1234, 16'h5678, 15'd0, 16'h1111, 0, '0),
			// zero radius leaves the core idle
			mk(mpc_pkg::KIND_STEP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 0, '0),
			mk(mpc_pkg::KIND_START, 16'hFFFF, 16'h0000, 15'd1, 16'hF800, 0, '0),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, 8,
				'{16'hFFFF, 16'h0000, 16'hF800, 1'b1, 1'b1}),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, 0, '0),
			mk(mpc_pkg::KIND_START, 16'h0000, 16'hFFFF, 15'd2, 16'h07E0, 0, '0),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, 8,
				'{16'h0001, 16'hFFFF, 16'h07E0, 1'b1, 1'b0}),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, 8,
				'{16'h0001, 16'hFFFE, 16'h07E0, 1'b1, 1'b1}),
			mk(mpc_pkg::KIND_START, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 0, '0),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, 8,
				'{16'h7FFD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}),
			mk(mpc_pkg::KIND_STEP, 16'h5555, 16'hAAAA, 15'h2AAA, 16'h5555, -1, '0),
			mk(mpc_pkg::KIND_STEP, 16'hAAAA, 16'h5555, 15'h5555, 16'hAAAA, -1, '0),
			// new circle replaces the running one
			mk(mpc_pkg::KIND_START, 16'h0000, 16'h0000, 15'h7FFF, 16'h0000, 0, '0),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, -1, '0),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, -1, '0),
			mk(mpc_pkg::KIND_START, 16'h8000, 16'h8000, 15'd3, 16'hA5A5, 0, '0),
			mk(mpc_pkg::KIND_STEP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, -1, '0),
			mk(mpc_pkg::KIND_STEP, 16'h1234, 16'h4321, 15'h0101, 16'h0F0F, -1, '0),
			mk(mpc_pkg::KIND_STEP, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 8,
				'{16'h8002, 16'h7FFE, 16'hA5A5, 1'b1, 1'b1}),
			mk(mpc_pkg::KIND_STEP, 16'h0000, 16'h0000, 15'd0, 16'h0000, 0, '0)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			offer(script[i].rq, n);
			if (script[i].n_pix >= 0) begin
				if (n != script[i].n_pix) begin
					$error("pixel count: expected %0d, got %0d", script[i].n_pix, n);
					mismatches++;
				end else if (n == 8) begin
					check_pixel(script[i].tail, pending_pixels[$]);
				end
			end
		end
		drain();

		target = item_count + RANDOM_ITEMS;
		while (item_count < target) begin
			calm = (item_count >= target - CALM_ITEMS);
			choice = $urandom_range(0, 99);
			if (choice < 5)
				drain();
			else if (choice < 25)
				repeat ($urandom_range(1, 4)) offer(random_item(1'($urandom)), n);
			else
				trace_circle();
		end

		drain();
		repeat (FLUSH_CYCLES) @(posedge clk);
		$display("covered %0d circle starts and %0d drawing steps, %0d circles drawn to the end",
			starts, draw_steps, circles_done);
		$display("%0d pixels compared, %0d mismatches", pixels_checked, mismatches);
		if (mismatches == 0)
			$display("tb_midpoint_circle_outline_core passed");
		else
			$display("tb_midpoint_circle_outline_core failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mpc_pkg.sv
hdl/mpc_engine.sv
hdl/mpc_emitter.sv
hdl/midpoint_circle_outline_core.sv
bench/tb_midpoint_circle_outline_core.sv
